>>> rtl/core/vlfd_pkg.sv
// shared types, codes and helpers for the varint length frame deframer
package vlfd_pkg;

	// width of the frame length accumulator
	localparam int LEN_BITS = 32;

	// input mode codes
	localparam logic [1:0] MODE_BYTE    = 2'd0;
	localparam logic [1:0] MODE_TIMEOUT = 2'd1;
	localparam logic [1:0] MODE_CLOSE   = 2'd2;

	// result event codes
	localparam logic [1:0] EV_BYTE   = 2'd0;
	localparam logic [1:0] EV_EMPTY  = 2'd1;
	localparam logic [1:0] EV_PING   = 2'd2;
	localparam logic [1:0] EV_CLOSED = 2'd3;

	// frame class codes
	localparam logic [1:0] CLS_TEXT    = 2'd0;
	localparam logic [1:0] CLS_BINARY  = 2'd1;
	localparam logic [1:0] CLS_PING    = 2'd2;
	localparam logic [1:0] CLS_UNKNOWN = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_TEXT_CODE   = 2'd0;
	localparam logic [1:0] REG_BINARY_CODE = 2'd1;
	localparam logic [1:0] REG_PING_CODE   = 2'd2;

	// reset values of the type codes
	localparam logic [7:0] TEXT_CODE_RST   = 8'd1;
	localparam logic [7:0] BINARY_CODE_RST = 8'd2;
	localparam logic [7:0] PING_CODE_RST   = 8'd3;

	// length group layout
	localparam int GROUP_BITS = 7;

	typedef enum logic [1:0] {
		STAGE_TYPE = 2'd0,
		STAGE_LEN  = 2'd1,
		STAGE_DATA = 2'd2
	} stage_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] in_byte;
	} vlfd_in_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [1:0] frame_class;
		logic [7:0] data_byte;
		logic       last;
	} vlfd_out_t;

	typedef struct packed {
		logic [7:0] text_code;
		logic [7:0] binary_code;
		logic [7:0] ping_code;
	} vlfd_cfg_t;

	// class of a type byte; text wins over binary, binary over ping
	function automatic logic [1:0] class_of(logic [7:0] t, vlfd_cfg_t cfg);
		logic [1:0] cls;
		if (t == cfg.text_code) begin
			cls = CLS_TEXT;
		end else if (t == cfg.binary_code) begin
			cls = CLS_BINARY;
		end else if (t == cfg.ping_code) begin
			cls = CLS_PING;
		end else begin
			cls = CLS_UNKNOWN;
		end
		return cls;
	endfunction

endpackage

>>> rtl/core/vlfd_cfg_regs.sv
// type code configuration registers
module vlfd_cfg_regs
	import vlfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output vlfd_cfg_t  cfg
);

	vlfd_cfg_t cfg_q;

	// register write decode, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_code   <= TEXT_CODE_RST;
			cfg_q.binary_code <= BINARY_CODE_RST;
			cfg_q.ping_code   <= PING_CODE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEXT_CODE:   cfg_q.text_code   <= cfg_data;
				REG_BINARY_CODE: cfg_q.binary_code <= cfg_data;
				REG_PING_CODE:   cfg_q.ping_code   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/vlfd_parser.sv
// input word register, frame parse state and keepalive watchdog
module vlfd_parser
	import vlfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  vlfd_in_t  in_data,
	input  vlfd_cfg_t cfg,
	output logic      res_valid,
	output vlfd_out_t res,
	input  logic      res_load_ok
);

	logic                valid_s1;
	vlfd_in_t            item_s1;
	stage_t              stage_q, stage_d;
	logic [7:0]          frame_type_q, frame_type_d;
	logic [LEN_BITS-1:0] remlen_q, remlen_d;
	logic                ping_pending_q, ping_pending_d;
	logic                link_up_q, link_up_d;
	logic                produce;
	logic                commit;
	logic [1:0]          cls;
	logic [LEN_BITS-1:0] len_shift;
	logic [LEN_BITS-1:0] len_dec;

	// the word in the input register moves on when it has no result or its result has room
	assign commit   = valid_s1 && (!produce || res_load_ok);
	assign in_ready = !valid_s1 || commit;
	assign res_valid = valid_s1 && produce;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// parse state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q        <= STAGE_TYPE;
			frame_type_q   <= '0;
			remlen_q       <= '0;
			ping_pending_q <= 1'b0;
			link_up_q      <= 1'b1;
		end else if (commit) begin
			stage_q        <= stage_d;
			frame_type_q   <= frame_type_d;
			remlen_q       <= remlen_d;
			ping_pending_q <= ping_pending_d;
			link_up_q      <= link_up_d;
		end
	end

	assign cls       = class_of(frame_type_q, cfg);
	assign len_shift = (remlen_q << GROUP_BITS) | LEN_BITS'(item_s1.in_byte[6:0]);
	assign len_dec   = remlen_q - LEN_BITS'(1);

	// next state and result
	always_comb begin
		stage_d        = stage_q;
		frame_type_d   = frame_type_q;
		remlen_d       = remlen_q;
		ping_pending_d = ping_pending_q;
		link_up_d      = link_up_q;
		produce        = 1'b0;
		res            = '0;
		if (link_up_q) begin
			case (item_s1.mode)
				MODE_TIMEOUT: begin
					produce = 1'b1;
					if (ping_pending_q) begin
						link_up_d     = 1'b0;
						res.event_res = EV_CLOSED;
					end else begin
						ping_pending_d = 1'b1;
						res.event_res  = EV_PING;
					end
				end
				MODE_CLOSE: begin
					produce       = 1'b1;
					link_up_d     = 1'b0;
					res.event_res = EV_CLOSED;
				end
				MODE_BYTE: begin
					ping_pending_d = 1'b0;
					unique case (stage_q)
						STAGE_TYPE: begin
							frame_type_d = item_s1.in_byte;
							remlen_d     = '0;
							stage_d      = STAGE_LEN;
						end
						STAGE_LEN: begin
							remlen_d = len_shift;
							if (!item_s1.in_byte[7]) begin
								if (len_shift == '0) begin
									stage_d = STAGE_TYPE;
									if (cls != CLS_UNKNOWN) begin
										produce         = 1'b1;
										res.event_res   = EV_EMPTY;
										res.frame_class = cls;
										res.last        = 1'b1;
									end
								end else begin
									stage_d = STAGE_DATA;
								end
							end
						end
						STAGE_DATA: begin
							remlen_d = len_dec;
							if (len_dec == '0) begin
								stage_d = STAGE_TYPE;
							end
							if (cls != CLS_UNKNOWN) begin
								produce         = 1'b1;
								res.event_res   = EV_BYTE;
								res.frame_class = cls;
								res.data_byte   = item_s1.in_byte;
								res.last        = (len_dec == '0);
							end
						end
						default: begin
							stage_d = STAGE_TYPE;
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	// a closed link stays silent
	a_no_result_when_down: assert property (@(posedge clk) disable iff (!arst_n)
		!link_up_q |-> !res_valid)
		else $error("result produced while link is down");

	// payload stage always has bytes left to take
	a_data_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == STAGE_DATA |-> remlen_q != '0)
		else $error("payload stage with zero remaining length");

	// a delivered close event takes the link down
	a_close_drops_link: assert property (@(posedge clk) disable iff (!arst_n)
		commit && res_valid && res.event_res == EV_CLOSED |=> !link_up_q)
		else $error("link still up after close event");

	// a ping request arms the watchdog
	a_ping_arms: assert property (@(posedge clk) disable iff (!arst_n)
		commit && res_valid && res.event_res == EV_PING |=> ping_pending_q)
		else $error("ping pending not set after ping request");

endmodule

>>> rtl/core/vlfd_out_reg.sv
// result word register toward the receiver
module vlfd_out_reg
	import vlfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	input  vlfd_out_t res,
	output logic      res_load_ok,
	output logic      out_valid,
	input  logic      out_ready,
	output vlfd_out_t out_data
);

	logic      out_valid_q;
	vlfd_out_t out_q;

	// register may load when empty or being drained this cycle
	assign res_load_ok = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load_ok) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load_ok && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/core/varint_length_frame_deframer_unit.sv
// top level of the varint length frame deframer
//
// Input channel in_valid/in_ready/in_data carries one word per cycle: a
// received byte, a read timeout or a close from the peer. Frames are a type
// byte, a big-endian length in 7-bit groups (bit 7 set means more follow),
// then the payload. Each payload byte of a known frame class comes out on
// out_valid/out_ready/out_data with its class and a last mark; a zero-length
// frame gives an empty-frame word; timeouts give a ping request and then a
// close. Unknown frame types are consumed with no output.
// After an input accept the word is parsed in the input register and its
// result loads the output register once that register has room; out_valid then rises.
// One word is accepted every cycle as long as the output is drained; the
// single parse step per word sets that rate.
// When the receiver stalls, the output register holds its word and the
// input register holds the next one; in_ready drops only when both are full
// and the next word has a result. Words with no result keep flowing.
// Reset (arst_n low) empties both registers, returns the parser to the type
// byte, clears the watchdog, marks the link up and loads the type codes
// 1, 2 and 3. cfg_ready is always high; the user writes only while idle, the block does not enforce it.
module varint_length_frame_deframer_unit
	import vlfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  vlfd_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output vlfd_out_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	vlfd_cfg_t cfg;
	logic      res_valid;
	vlfd_out_t res;
	logic      res_load_ok;

	assign cfg_ready = 1'b1;

	// type code registers
	vlfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// parse step
	vlfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res         (res),
		.res_load_ok (res_load_ok)
	);

	// output register
	vlfd_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res         (res),
		.res_load_ok (res_load_ok),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

>>> test/tb_varint_length_frame_deframer_unit.sv
// testbench for the varint length frame deframer: directed and random words checked by a scoreboard
module tb_varint_length_frame_deframer_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import vlfd_pkg::*;

	// mode code with no meaning, ignored by the block
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// register index that maps to no register
	localparam logic [1:0] REG_UNUSED = 2'd3;
	// cycles to let in-flight words settle once nothing is awaited
	localparam int SETTLE_CYCLES = 6;

	// tracks parser, watchdog and link state and holds the words still owed
	class deframer_scoreboard;
		vlfd_cfg_t           codes;
		stage_t              stage;
		logic [7:0]          frame_type;
		logic [LEN_BITS-1:0] remaining;
		bit                  ping_pending;
		bit                  link_up;
		vlfd_out_t           expected_words[$];
		int                  errors;

		function new();
			codes.text_code   = TEXT_CODE_RST;
			codes.binary_code = BINARY_CODE_RST;
			codes.ping_code   = PING_CODE_RST;
			stage        = STAGE_TYPE;
			frame_type   = '0;
			remaining    = '0;
			ping_pending = 1'b0;
			link_up      = 1'b1;
			errors       = 0;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void load_code(logic [1:0] idx, logic [7:0] val);
			case (idx)
				REG_TEXT_CODE:   codes.text_code = val;
				REG_BINARY_CODE: codes.binary_code = val;
				REG_PING_CODE:   codes.ping_code = val;
				default: ;
			endcase
		endfunction

		function void queue_word(logic [1:0] ev, logic [1:0] cls, logic [7:0] data,
				logic last_mark);
			vlfd_out_t w;
			w.event_res   = ev;
			w.frame_class = cls;
			w.data_byte   = data;
			w.last        = last_mark;
			expected_words = {expected_words, w};
		endfunction

		// advance the state by one accepted input word
		function void note_input(vlfd_in_t w);
			logic [1:0] cls;
			if (!link_up) begin
				return;
			end
			// first match wins: text, then binary, then ping
			if (frame_type == codes.text_code) begin
				cls = CLS_TEXT;
			end else if (frame_type == codes.binary_code) begin
				cls = CLS_BINARY;
			end else if (frame_type == codes.ping_code) begin
				cls = CLS_PING;
			end else begin
				cls = CLS_UNKNOWN;
			end
			case (w.mode)
				// class field reads as text (zero) on link events
				MODE_TIMEOUT: begin
					if (ping_pending) begin
						link_up = 1'b0;
						queue_word(EV_CLOSED, CLS_TEXT, 8'h00, 1'b0);
					end else begin
						ping_pending = 1'b1;
						queue_word(EV_PING, CLS_TEXT, 8'h00, 1'b0);
					end
				end
				MODE_CLOSE: begin
					link_up = 1'b0;
					queue_word(EV_CLOSED, CLS_TEXT, 8'h00, 1'b0);
				end
				MODE_BYTE: begin
					ping_pending = 1'b0;
					case (stage)
						STAGE_TYPE: begin
							frame_type = w.in_byte;
							remaining  = '0;
							stage      = STAGE_LEN;
						end
						STAGE_LEN: begin
							remaining = (remaining << GROUP_BITS) | LEN_BITS'(w.in_byte[6:0]);
							if (!w.in_byte[7]) begin
								if (remaining == '0) begin
									stage = STAGE_TYPE;
									if (cls != CLS_UNKNOWN) begin
										queue_word(EV_EMPTY, cls, 8'h00, 1'b1);
									end
								end else begin
									stage = STAGE_DATA;
								end
							end
						end
						STAGE_DATA: begin
							remaining = remaining - LEN_BITS'(1);
							if (remaining == '0) begin
								stage = STAGE_TYPE;
							end
							if (cls != CLS_UNKNOWN) begin
								queue_word(EV_BYTE, cls, w.in_byte, remaining == '0);
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40) begin
				$display("mismatch at %0t ns: %s", $time, what);
			end
		endtask

		// compare one accepted result word with the oldest one owed
		task check_word(vlfd_out_t got);
			vlfd_out_t want;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", got));
				return;
			end
			want = expected_words.pop_front();
			if (got.event_res !== want.event_res) begin
				report_mismatch($sformatf("event_res %0d, wanted %0d",
					got.event_res, want.event_res));
			end
			if (got.frame_class !== want.frame_class) begin
				report_mismatch($sformatf("frame_class %0d, wanted %0d",
					got.frame_class, want.frame_class));
			end
			if (got.data_byte !== want.data_byte) begin
				report_mismatch($sformatf("data_byte %h, wanted %h",
					got.data_byte, want.data_byte));
			end
			if (got.last !== want.last) begin
				report_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	vlfd_in_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	vlfd_out_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	deframer_scoreboard sb;
	vlfd_cfg_t   cur_codes;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned items_sent = 0;
	bit          watchdog_armed = 1'b0;
	bit          noise_on = 1'b0;

	varint_length_frame_deframer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver stalls at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// watch all three handshakes; results are checked before the new word is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sb.check_word(out_data);
			end
			if (in_valid && in_ready) begin
				sb.note_input(in_data);
			end
			if (cfg_valid && cfg_ready) begin
				sb.load_code(cfg_index, cfg_data);
			end
		end
	end

	// offer one word, idling first at the phase rate, and hold it until taken
	task automatic send_word(logic [1:0] mode, logic [7:0] in_byte);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		in_data.mode    <= mode;
		in_data.in_byte <= in_byte;
		do @(posedge clk); while (!in_ready);
		if (mode != MODE_UNUSED) begin
			items_sent++;
		end
		if (mode == MODE_TIMEOUT) begin
			watchdog_armed = 1'b1;
		end else if (mode == MODE_BYTE) begin
			watchdog_armed = 1'b0;
		end
	endtask

	// stream byte, with timeouts and unused-mode noise mixed in when enabled
	task automatic put_byte(logic [7:0] b);
		if (noise_on) begin
			// never a second timeout in a row, so the link stays up
			if (!watchdog_armed && $urandom_range(99) < 4) begin
				send_word(MODE_TIMEOUT, 8'($urandom));
			end
			if ($urandom_range(99) < 3) begin
				send_word(MODE_UNUSED, 8'($urandom));
			end
		end
		send_word(MODE_BYTE, b);
	endtask

	task automatic write_code(logic [1:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TEXT_CODE:   cur_codes.text_code = val;
			REG_BINARY_CODE: cur_codes.binary_code = val;
			REG_PING_CODE:   cur_codes.ping_code = val;
			default: ;
		endcase
	endtask

	// hold the sender off until every owed word has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// payload byte, often one that looks like frame framing
	function automatic logic [7:0] payload_byte();
		logic [7:0] b;
		case ($urandom_range(11))
			0: b = cur_codes.text_code;
			1: b = cur_codes.binary_code;
			2: b = cur_codes.ping_code;
			3: b = 8'h80;
			4: b = 8'h00;
			5: b = 8'hFF;
			default: b = 8'($urandom);
		endcase
		return b;
	endfunction

	// type byte, length groups (bits above 32 in high, pad leading zero groups), payload
	task automatic send_frame(logic [7:0] ftype, int unsigned len, int unsigned pad,
			logic [31:0] high);
		logic [63:0] v;
		int unsigned groups;
		logic [6:0]  g;
		v = {high, 32'(len)};
		groups = 1;
		while (groups < 10 && (v >> (GROUP_BITS * groups)) != 0) groups++;
		put_byte(ftype);
		for (int i = groups + pad - 1; i >= 0; i--) begin
			g = (i < groups) ? 7'(v >> (GROUP_BITS * i)) : 7'h00;
			put_byte({i != 0, g});
		end
		for (int unsigned k = 0; k < len; k++) begin
			put_byte(payload_byte());
		end
	endtask

	// random frames, mostly short and of known types, until target words went in
	task automatic run_random(int unsigned target);
		int unsigned start;
		int unsigned r;
		int unsigned len;
		int unsigned pad;
		logic [7:0]  ftype;
		logic [31:0] high;
		start = items_sent;
		noise_on = 1'b1;
		while (items_sent - start < target) begin
			r = $urandom_range(99);
			if (r < 30) begin
				ftype = cur_codes.text_code;
			end else if (r < 55) begin
				ftype = cur_codes.binary_code;
			end else if (r < 80) begin
				ftype = cur_codes.ping_code;
			end else begin
				ftype = 8'($urandom);
			end
			r = $urandom_range(99);
			if (r < 55) begin
				len = $urandom_range(4);
			end else if (r < 85) begin
				len = $urandom_range(12, 5);
			end else if (r < 98) begin
				len = $urandom_range(40, 13);
			end else begin
				len = $urandom_range(200, 128);
			end
			pad  = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0;
			high = ($urandom_range(19) == 0) ? $urandom : 32'h0;
			send_frame(ftype, len, pad, high);
		end
		noise_on = 1'b0;
	endtask

	initial begin
		sb = new();
		cur_codes.text_code   = TEXT_CODE_RST;
		cur_codes.binary_code = BINARY_CODE_RST;
		cur_codes.ping_code   = PING_CODE_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset codes, no idling
		// text frame of two bytes with a timeout inside it
		send_word(MODE_BYTE, 8'h01);
		send_word(MODE_BYTE, 8'h02);
		send_word(MODE_TIMEOUT, 8'h00);
		send_word(MODE_BYTE, 8'h00);
		send_word(MODE_BYTE, 8'hFF);
		// empty binary frame
		send_word(MODE_BYTE, 8'h02);
		send_word(MODE_BYTE, 8'h00);
		// ping frame with a leading zero length group
		send_word(MODE_BYTE, 8'h03);
		send_word(MODE_BYTE, 8'h80);
		send_word(MODE_BYTE, 8'h01);
		send_word(MODE_BYTE, 8'h5A);
		// unknown type, one byte and then empty
		send_word(MODE_BYTE, 8'hC3);
		send_word(MODE_BYTE, 8'h01);
		send_word(MODE_BYTE, 8'h7E);
		send_word(MODE_BYTE, 8'h00);
		send_word(MODE_BYTE, 8'h00);
		// ping request, then unused mode leaves the watchdog armed
		send_word(MODE_TIMEOUT, 8'hFF);
		send_word(MODE_UNUSED, 8'hFF);
		// length whose low 32 bits are zero gives an empty text frame
		send_frame(cur_codes.text_code, 0, 0, 32'h2);

		// no idling on either side
		run_random(140);
		drain_results();

		// sender idle often; extreme and unused register writes
		write_code(REG_TEXT_CODE, 8'h00);
		write_code(REG_BINARY_CODE, 8'hFF);
		write_code(REG_PING_CODE, 8'h80);
		write_code(REG_UNUSED, 8'h5A);
		idle_pct = 73;
		run_random(160);
		drain_results();

		// receiver stalls often; text and binary codes collide
		write_code(REG_TEXT_CODE, 8'h55);
		write_code(REG_BINARY_CODE, 8'h55);
		write_code(REG_PING_CODE, 8'hAA);
		idle_pct  = 0;
		stall_pct = 73;
		run_random(160);
		drain_results();

		// both sides idle now and then; binary and ping codes collide
		write_code(REG_TEXT_CODE, 8'h7F);
		write_code(REG_BINARY_CODE, 8'h01);
		write_code(REG_PING_CODE, 8'h01);
		idle_pct  = 23;
		stall_pct = 23;
		run_random(160);

		// take the link down by a double timeout or a peer close, then nothing counts
		if ($urandom_range(1) == 1) begin
			send_word(MODE_TIMEOUT, 8'($urandom));
			send_word(MODE_TIMEOUT, 8'($urandom));
		end else begin
			send_word(MODE_CLOSE, 8'($urandom));
		end
		send_word(MODE_BYTE, 8'h01);
		send_word(MODE_TIMEOUT, 8'($urandom));
		send_word(MODE_CLOSE, 8'($urandom));
		send_word(MODE_UNUSED, 8'($urandom));
		drain_results();

		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// hard stop if the handshakes hang
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
